FILE: src/gcs_pkg.sv
// Shared types and constants for the graph coloring search block.
// Used by every module under src; depends on nothing.
package gcs_pkg;

	// Payload field widths
	localparam int IDX_W = 4;
	localparam int ROW_W = 16;
	localparam int CW = 5;
	localparam int CFG_W = 5;
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 8;

	// Default store depth
	localparam int DEF_MAX_NODES = 16;

	// Color code of a node that holds no color
	localparam logic [CW-1:0] UNCOLORED = 5'd31;

	// Configuration register indexes
	localparam logic REG_NUM_NODES = 1'b0;
	localparam logic REG_NUM_COLORS = 1'b1;

	// Register values after reset
	localparam logic [CFG_W-1:0] RESET_NUM_NODES = 5'd16;
	localparam logic [CFG_W-1:0] RESET_NUM_COLORS = 5'd3;

	// Commands from the sequencer to the color unit
	typedef struct packed {
		logic clear_all;
		logic set_color;
		logic clear_color;
	} cu_cmd_t;

endpackage

FILE: src/graph_m_coloring_search.sv
// Graph m-coloring search: row loader, backtracking sequencer, result register.
// Depends on gcs_pkg, gcs_adj_store and gcs_color_unit.
//
// Usage:
//   Rows of the adjacency matrix arrive on the s_ channel, one request per row,
//   and are stored; s_tready stays high while no search runs.
//   A row with s_tlast high is stored and then starts the search over nodes
//   0 .. min(num_nodes, MAX_NODES)-1 with num_colors colors. s_tready is
//   low until it ends. The search tries one (node, color) pair per cycle on
//   a single conflict compare unit: it sets up in ST_INIT, then in ST_STEP
//   tries a pair or takes a backtrack step until it finds the search finished,
//   and posts the result from ST_DONE; its run time is data dependent.
//   The yes/no answer leaves on the m_ channel through an output register; if
//   the receiver stalls, the register holds and the block still takes new
//   rows, but a finished search waits until the register is free.
//   Configuration writes (cfg_we, cfg_addr, cfg_wdata) must only happen while
//   the block is idle.
//   Reset clears the sequencer, the output register and the colors, and sets
//   num_nodes to 16 and num_colors to 3; stored rows are undefined until
//   written.
module graph_m_coloring_search
	import gcs_pkg::*;
#(
	parameter int MAX_NODES = DEF_MAX_NODES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // node_index[3:0], adjacency_row[19:4], zero pad
	input  logic                s_tlast,  // last_row
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,  // colorable[0], zero pad
	input  logic                cfg_we,
	input  logic                cfg_addr,
	input  logic [CFG_W-1:0]    cfg_wdata
);

	localparam int NIW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int DW = $clog2(MAX_NODES + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_INIT = 2'd1;
	localparam logic [1:0] ST_STEP = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]           state_q;
	logic [CFG_W-1:0]     num_nodes_q;
	logic [CFG_W-1:0]     num_colors_q;
	logic [DW-1:0]        depth_q;
	logic [CW-1:0]        cand_q;
	logic                 result_q;
	logic                 out_valid_q;
	logic                 out_data_q;

	logic                 s_req;
	logic [DW-1:0]        n_sat;
	logic [DW-1:0]        depth_m1;
	logic [MAX_NODES-1:0] nbr_mask;
	logic                 conflict;
	logic [CW-1:0]        used;
	logic [CW-1:0]        prev_color;
	logic [CW-1:0]        used_p1;
	logic [CW-1:0]        limit;
	logic                 at_end;
	logic                 try_ok;
	cu_cmd_t              cmd;

	assign s_tready = (state_q == ST_IDLE);
	assign s_req = s_tvalid && s_tready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_nodes_q <= RESET_NUM_NODES;
			num_colors_q <= RESET_NUM_COLORS;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_NUM_NODES:  num_nodes_q <= cfg_wdata;
				REG_NUM_COLORS: num_colors_q <= cfg_wdata;
				default:        num_nodes_q <= num_nodes_q;
			endcase
		end
	end

	// Saturate the node count to the store depth
	assign n_sat = (32'(num_nodes_q) > MAX_NODES) ? DW'(MAX_NODES) : DW'(num_nodes_q);
	assign depth_m1 = depth_q - DW'(1);

	gcs_adj_store #(
		.MAX_NODES(MAX_NODES),
		.NIW      (NIW)
	) u_adj (
		.clk     (clk),
		.wr_en   (s_req),
		.wr_idx  (s_tdata[IDX_W-1:0]),
		.wr_row  (s_tdata[IDX_W+ROW_W-1:IDX_W]),
		.node    (depth_q[NIW-1:0]),
		.nbr_mask(nbr_mask)
	);

	gcs_color_unit #(
		.MAX_NODES(MAX_NODES),
		.NIW      (NIW)
	) u_color (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.node      (depth_q[NIW-1:0]),
		.prev_node (depth_m1[NIW-1:0]),
		.cand      (cand_q),
		.nbr_mask  (nbr_mask),
		.conflict  (conflict),
		.used      (used),
		.prev_color(prev_color)
	);

	// Colors allowed here: those in use plus the next fresh one, capped by m
	assign used_p1 = used + CW'(1);
	assign limit = (used_p1 < num_colors_q) ? used_p1 : num_colors_q;
	assign at_end = (depth_q >= n_sat);
	assign try_ok = (cand_q < limit);

	// Commands to the color unit
	always_comb begin
		cmd = '0;
		if (state_q == ST_INIT) begin
			cmd.clear_all = 1'b1;
		end else if (state_q == ST_STEP && !at_end) begin
			if (try_ok) begin
				cmd.set_color = !conflict;
			end else begin
				cmd.clear_color = 1'b1;
			end
		end
	end

	// Search sequencer: advance on a safe color, try the next one, or backtrack
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			depth_q <= '0;
			cand_q <= '0;
			result_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_req && s_tlast) begin
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					depth_q <= '0;
					cand_q <= '0;
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					if (at_end) begin
						result_q <= 1'b1;
						state_q <= ST_DONE;
					end else if (try_ok) begin
						if (conflict) begin
							cand_q <= cand_q + CW'(1);
						end else begin
							depth_q <= depth_q + DW'(1);
							cand_q <= '0;
						end
					end else if (depth_q == '0) begin
						result_q <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						depth_q <= depth_m1;
						cand_q <= prev_color + CW'(1);
					end
				end
				ST_DONE: begin
					if (!out_valid_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register: load when free, drop on a taken request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && !out_valid_q) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && !out_valid_q) begin
			out_data_q <= result_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {{(M_DATA_W-1){1'b0}}, out_data_q};

endmodule

FILE: src/gcs_adj_store.sv
// Adjacency row store and neighbor mask for the node under test.
// Depends on gcs_pkg.
module gcs_adj_store
	import gcs_pkg::*;
#(
	parameter int MAX_NODES = DEF_MAX_NODES,
	parameter int NIW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [IDX_W-1:0]     wr_idx,
	input  logic [ROW_W-1:0]     wr_row,
	input  logic [NIW-1:0]       node,
	output logic [MAX_NODES-1:0] nbr_mask
);

	logic [ROW_W-1:0] rows_q [MAX_NODES];
	logic [ROW_W-1:0] row_k;

	// Store a row; indexes past the store are dropped
	always_ff @(posedge clk) begin
		for (int j = 0; j < MAX_NODES; j++) begin
			if (wr_en && 32'(wr_idx) == j) begin
				rows_q[j] <= wr_row;
			end
		end
	end

	assign row_k = rows_q[node];

	// Neighbors below the node: either row may carry the edge
	for (genvar j = 0; j < MAX_NODES; j++) begin : g_mask
		logic [ROW_W-1:0] col_sh;
		logic row_bit;
		assign col_sh = rows_q[j] >> node;
		if (j < ROW_W) begin : g_in_row
			assign row_bit = row_k[j];
		end else begin : g_past_row
			assign row_bit = 1'b0;
		end
		assign nbr_mask[j] = (32'(node) > j) && (row_bit || col_sh[0]);
	end

endmodule

FILE: src/gcs_color_unit.sv
// Node colors, prefix count of colors in use, and the shared conflict compare.
// Depends on gcs_pkg.
module gcs_color_unit
	import gcs_pkg::*;
#(
	parameter int MAX_NODES = DEF_MAX_NODES,
	parameter int NIW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cu_cmd_t              cmd,
	input  logic [NIW-1:0]       node,
	input  logic [NIW-1:0]       prev_node,
	input  logic [CW-1:0]        cand,
	input  logic [MAX_NODES-1:0] nbr_mask,
	output logic                 conflict,
	output logic [CW-1:0]        used,
	output logic [CW-1:0]        prev_color
);

	logic [CW-1:0]        color_q [MAX_NODES];
	logic [CW-1:0]        used_q  [MAX_NODES];
	logic [MAX_NODES-1:0] match;
	logic [CW-1:0]        cand_p1;
	logic [CW-1:0]        used_next;

	assign cand_p1 = cand + CW'(1);
	assign used_next = (cand_p1 > used) ? cand_p1 : used;

	// Update colors and the colors-in-use count of the next node
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_NODES; j++) begin
				color_q[j] <= UNCOLORED;
				used_q[j] <= '0;
			end
		end else if (cmd.clear_all) begin
			for (int j = 0; j < MAX_NODES; j++) begin
				color_q[j] <= UNCOLORED;
				used_q[j] <= '0;
			end
		end else begin
			for (int j = 0; j < MAX_NODES; j++) begin
				if (32'(node) == j) begin
					if (cmd.set_color) begin
						color_q[j] <= cand;
					end else if (cmd.clear_color) begin
						color_q[j] <= UNCOLORED;
					end
				end
				if (cmd.set_color && j > 0 && 32'(node) == j - 1) begin
					used_q[j] <= used_next;
				end
			end
		end
	end

	// Compare the candidate against every colored neighbor at once
	for (genvar j = 0; j < MAX_NODES; j++) begin : g_cmp
		assign match[j] = (color_q[j] == cand);
	end

	assign conflict = |(match & nbr_mask);
	assign used = used_q[node];
	assign prev_color = color_q[prev_node];

endmodule

FILE: src/gcs_checker.sv
// Port-level checks for the graph coloring search block, bound to the top level.
// Depends on gcs_pkg.
module gcs_checker
	import gcs_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                s_tlast,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped or changed while stalled");

	// A plain row does not start a search
	a_row_stays_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tlast |=> s_tready)
		else $error("block went busy after a plain row");

	// The last row starts a search that blocks further rows
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("block still ready after the last row");

	// Only the answer bit may be set
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[M_DATA_W-1:1] == '0)
		else $error("padding bits set in result");

endmodule

bind graph_m_coloring_search gcs_checker u_gcs_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tlast (s_tlast),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

FILE: verif/graph_m_coloring_search_test.sv
// Self-checking testbench for graph_m_coloring_search: loads adjacency rows,
// runs coloring searches under many register settings and checks every verdict.
// Depends on gcs_pkg and the graph_m_coloring_search RTL only.
module graph_m_coloring_search_test
	import gcs_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAXN = DEF_MAX_NODES;
	localparam int NO_COLOR = -1;
	localparam int IDLE_PCT = 19;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 600;
	localparam int STEP_CAP = 1500;
	localparam int ROW_TARGET = 650;

	typedef logic [MAXN-1:0][ROW_W-1:0] adj_matrix_t;

	typedef enum logic {ACT_ROW, ACT_CFG} act_t;

	typedef struct {
		act_t             act;
		logic [CFG_W-1:0] nodes;
		logic [CFG_W-1:0] colors;
		logic [IDX_W-1:0] idx;
		logic [ROW_W-1:0] row;
		bit               last;
		int               want;
	} step_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic                s_tlast;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic                cfg_we;
	logic                cfg_addr;
	logic [CFG_W-1:0]    cfg_wdata;

	// Mirror of the block as seen through accepted requests
	adj_matrix_t      adj_mirror;
	logic [CFG_W-1:0] nodes_mirror = 5'd16;
	logic [CFG_W-1:0] colors_mirror = 5'd3;
	// Rows as planned by the stimulus, ahead of acceptance
	adj_matrix_t      adj_planned;

	bit     pending_verdicts [$];
	int     cur_want = -1;
	int     mismatches = 0;
	int     rows_sent = 0;
	longint cycles = 0;
	longint cycle_limit = 200000;
	bit     steady = 1'b0;
	bit     hold_request = 1'b0;

	step_t directed_steps [31];

	graph_m_coloring_search u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Decide colorability by complete backtracking; count tried pairs and
	// backtrack steps as a cost estimate
	function automatic bit color_search(input adj_matrix_t adj, input logic [CFG_W-1:0] nodes,
			input logic [CFG_W-1:0] colors, output int steps);
		int n, m, depth, used, lim, c, j;
		int hue [MAXN];
		int resume [MAXN];
		bit clash;
		steps = 0;
		n = (nodes > MAXN) ? MAXN : int'(nodes);
		m = int'(colors);
		for (j = 0; j < MAXN; j++) begin
			hue[j] = NO_COLOR;
			resume[j] = 0;
		end
		if (n == 0)
			return 1'b1;
		if (m == 0)
			return 1'b0;
		depth = 0;
		forever begin
			if (depth >= n)
				return 1'b1;
			// allow colors in use plus the next fresh one
			used = 0;
			for (j = 0; j < depth; j++)
				if (hue[j] + 1 > used)
					used = hue[j] + 1;
			lim = (used + 1 < m) ? used + 1 : m;
			c = resume[depth];
			clash = 1'b1;
			while (c < lim && clash) begin
				steps++;
				clash = 1'b0;
				// an edge exists if either row marks it; self loops never match
				for (j = 0; j < depth; j++)
					if (hue[j] == c && (adj[depth][j] || adj[j][depth]))
						clash = 1'b1;
				if (clash)
					c++;
			end
			steps++;
			if (c < lim) begin
				hue[depth] = c;
				resume[depth] = c + 1;
				depth++;
				if (depth < MAXN)
					resume[depth] = 0;
			end else begin
				hue[depth] = NO_COLOR;
				resume[depth] = 0;
				if (depth == 0)
					return 1'b0;
				depth--;
			end
		end
	endfunction

	task automatic note_mismatch(input string what);
		$display("MISMATCH cycle %0d: %s", cycles, what);
		mismatches++;
	endtask

	// Offer one row request and hold it until accepted
	task automatic send_row(input logic [IDX_W-1:0] idx, input logic [ROW_W-1:0] row,
			input bit last, input int want);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(S_DATA_W - IDX_W - ROW_W){1'b0}}, row, idx};
		s_tlast <= last;
		cur_want <= want;
		adj_planned[idx] = row;
		rows_sent++;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Wait for every verdict, then let the row loader go quiet
	task automatic drain_block();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [CFG_W-1:0] nodes, input logic [CFG_W-1:0] colors);
		drain_block();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= REG_NUM_NODES;
		cfg_wdata <= nodes;
		@(negedge clk);
		cfg_addr <= REG_NUM_COLORS;
		cfg_wdata <= colors;
		@(negedge clk);
		cfg_we <= 1'b0;
		nodes_mirror = nodes;
		colors_mirror = colors;
	endtask

	// Send a burst of random rows, usually closed by a search request;
	// redraw graphs whose search would run too long
	task automatic send_frame(input bit force_last);
		logic [IDX_W-1:0] idxs [$];
		logic [ROW_W-1:0] rows [$];
		adj_matrix_t trial;
		logic [IDX_W-1:0] i;
		logic [ROW_W-1:0] r;
		int span, k, tries, steps, density;
		bit ends_search, cheap;
		span = (nodes_mirror > MAXN) ? MAXN : int'(nodes_mirror);
		if (span == 0)
			span = 1;
		ends_search = force_last || ($urandom_range(0, 99) < 88);
		cheap = 1'b0;
		for (tries = 0; tries < 8 && !cheap; tries++) begin
			trial = adj_planned;
			idxs.delete();
			rows.delete();
			k = $urandom_range(1, span);
			density = $urandom_range(0, 3);
			repeat (k) begin
				if ($urandom_range(0, 4) != 0)
					i = IDX_W'($urandom_range(0, span - 1));
				else
					i = IDX_W'($urandom);
				case (density)
					0: r = ROW_W'($urandom & $urandom & $urandom);
					1: r = ROW_W'($urandom & $urandom);
					2: r = ROW_W'($urandom);
					default: begin
						case ($urandom_range(0, 2))
							0: r = '0;
							1: r = '1;
							default: r = ROW_W'($urandom);
						endcase
					end
				endcase
				idxs.push_back(i);
				rows.push_back(r);
				trial[i] = r;
			end
			if (!ends_search) begin
				cheap = 1'b1;
			end else begin
				void'(color_search(trial, nodes_mirror, colors_mirror, steps));
				cheap = (steps <= STEP_CAP);
			end
		end
		// fall back to an empty graph, which searches without backtracking
		if (!cheap) begin
			idxs.delete();
			rows.delete();
			for (k = 0; k < MAXN; k++) begin
				idxs.push_back(IDX_W'(k));
				rows.push_back('0);
			end
		end
		foreach (idxs[q])
			send_row(idxs[q], rows[q], ends_search && (q == idxs.size() - 1), -1);
	endtask

	// Mirror each accepted row and predict a verdict for each accepted search request
	always @(posedge clk) begin
		int steps;
		bit verdict;
		if (arst_n && s_tvalid && s_tready) begin
			adj_mirror[s_tdata[IDX_W-1:0]] = s_tdata[IDX_W+ROW_W-1:IDX_W];
			cycle_limit += 64;
			if (s_tlast) begin
				verdict = color_search(adj_mirror, nodes_mirror, colors_mirror, steps);
				if (cur_want >= 0)
					verdict = cur_want[0];
				pending_verdicts.push_back(verdict);
				cycle_limit += 8 * steps + 200;
			end
		end
	end

	// Compare each delivered verdict with the oldest prediction
	always @(posedge clk) begin
		bit want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_verdicts.size() == 0) begin
				note_mismatch($sformatf("unexpected result, colorable=%0b", m_tdata[0]));
			end else begin
				want = pending_verdicts.pop_front();
				if (m_tdata[0] !== want)
					note_mismatch($sformatf("colorable=%0b, predicted %0b", m_tdata[0], want));
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles > cycle_limit) begin
			$display("graph_m_coloring_search verification failed");
			$finish;
		end
	end

	// Drive the result side: random stalls, one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				m_tready <= arst_n && (steady || $urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	initial begin
		int phase;
		int frames;
		logic [CFG_W-1:0] n_pick, m_pick;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = REG_NUM_NODES;
		cfg_wdata = '0;
		adj_mirror = '0;
		adj_planned = '0;

		// Directed: fill every row (K4 on nodes 0..3, node 0 joined to all and
		// looped on itself), then walk the register corners
		directed_steps = '{
			'{ACT_ROW, 5'd0, 5'd0, 4'd0, 16'hFFFF, 1'b0, -1},
			'{ACT_ROW, 5'd0, 5'd0, 4'd1, 16'h000C, 1'b0, -1},
			'{ACT_ROW, 5'd0, 5'd0, 4'd2, 16'h0008, 1'b0, -1},
			'{ACT_ROW, 5'd0, 5'd0, 4'd3, 16'h0000, 1'b0, -1},
			'{ACT_ROW, 5'd0, 5'd0, 4'd4, 16'h0000, 1'b0, -1},
			'{ACT_ROW, 5'd0, 5'd0, 4'd5, 16'h0000, 1'b0, -1},
			'{ACT_ROW, 5'd0, 5'd0, 4'd6, 16'h0000, 1'b0, -1},
			'{ACT_ROW, 5'd0, 5'd0, 4'd7, 16'h0000, 1'b0, -1},
			'{ACT_ROW, 5'd0, 5'd0, 4'd8, 16'h0000, 1'b0, -1},
			'{ACT_ROW, 5'd0, 5'd0, 4'd9, 16'h0000, 1'b0, -1},
			'{ACT_ROW, 5'd0, 5'd0, 4'd10, 16'h0000, 1'b0, -1},
			'{ACT_ROW, 5'd0, 5'd0, 4'd11, 16'h0000, 1'b0, -1},
			'{ACT_ROW, 5'd0, 5'd0, 4'd12, 16'h0000, 1'b0, -1},
			'{ACT_ROW, 5'd0, 5'd0, 4'd13, 16'h0000, 1'b0, -1},
			'{ACT_ROW, 5'd0, 5'd0, 4'd14, 16'h0000, 1'b0, -1},
			// K4 with the reset setting of three colors
			'{ACT_ROW, 5'd0, 5'd0, 4'd15, 16'h8000, 1'b1, 0},
			'{ACT_CFG, 5'd16, 5'd4, 4'd0, 16'h0000, 1'b0, -1},
			// stored rows persist into a new search
			'{ACT_ROW, 5'd0, 5'd0, 4'd3, 16'h0000, 1'b1, 1},
			// no nodes
			'{ACT_CFG, 5'd0, 5'd0, 4'd0, 16'h0000, 1'b0, -1},
			'{ACT_ROW, 5'd0, 5'd0, 4'd5, 16'h0000, 1'b1, 1},
			// no colors
			'{ACT_CFG, 5'd1, 5'd0, 4'd0, 16'h0000, 1'b0, -1},
			'{ACT_ROW, 5'd0, 5'd0, 4'd5, 16'h0000, 1'b1, 0},
			// self loop on node 0 ignored
			'{ACT_CFG, 5'd1, 5'd1, 4'd0, 16'h0000, 1'b0, -1},
			'{ACT_ROW, 5'd0, 5'd0, 4'd6, 16'h0000, 1'b1, 1},
			// edge 0-1 marked in row 0 only
			'{ACT_CFG, 5'd2, 5'd1, 4'd0, 16'h0000, 1'b0, -1},
			'{ACT_ROW, 5'd0, 5'd0, 4'd1, 16'h000C, 1'b1, 0},
			// node count saturates, colors plentiful
			'{ACT_CFG, 5'd31, 5'd31, 4'd0, 16'h0000, 1'b0, -1},
			'{ACT_ROW, 5'd0, 5'd0, 4'd14, 16'hFFFF, 1'b1, 1},
			'{ACT_CFG, 5'd17, 5'd2, 4'd0, 16'h0000, 1'b0, -1},
			'{ACT_ROW, 5'd0, 5'd0, 4'd9, 16'h5A5A, 1'b0, -1},
			'{ACT_ROW, 5'd0, 5'd0, 4'd7, 16'h0001, 1'b1, -1}
		};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_steps[s]) begin
			if (directed_steps[s].act == ACT_CFG)
				set_config(directed_steps[s].nodes, directed_steps[s].colors);
			else
				send_row(directed_steps[s].idx, directed_steps[s].row,
					directed_steps[s].last, directed_steps[s].want);
		end

		// Random phases: new setting, then bursts of rows and searches
		phase = 0;
		while (rows_sent < ROW_TARGET) begin
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 4))
					0: n_pick = 5'd0;
					1: n_pick = 5'd1;
					2: n_pick = 5'd16;
					3: n_pick = 5'd17;
					default: n_pick = 5'd31;
				endcase
			end else begin
				n_pick = CFG_W'($urandom_range(2, 12));
			end
			if ($urandom_range(0, 4) == 0) begin
				case ($urandom_range(0, 3))
					0: m_pick = 5'd0;
					1: m_pick = 5'd1;
					2: m_pick = 5'd16;
					default: m_pick = 5'd31;
				endcase
			end else begin
				m_pick = CFG_W'($urandom_range(2, 4));
			end
			set_config(n_pick, m_pick);
			steady = (phase == 4);
			// hold the result side so finished searches back up into the input
			if (phase == 2)
				hold_request = 1'b1;
			frames = $urandom_range(3, 6);
			repeat (frames) send_frame(phase == 2);
			phase++;
		end

		drain_block();
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("graph_m_coloring_search verification clean");
		else
			$display("graph_m_coloring_search verification failed");
		$finish;
	end

endmodule

FILE: sim.f
src/gcs_pkg.sv
src/gcs_adj_store.sv
src/gcs_color_unit.sv
src/graph_m_coloring_search.sv
src/gcs_checker.sv
verif/graph_m_coloring_search_test.sv
